/* rtl/rpwc_pkg.sv */
// shared types, constants and codes for the rc pulse width capture block
// no dependencies
`default_nettype none

package rpwc_pkg;

  localparam int unsigned NUM_CHANNELS = 8;
  localparam int unsigned CH_W         = 3;
  localparam int unsigned TIME_W       = 16;
  localparam int unsigned MODE_W       = 2;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam logic [MODE_W-1:0] MODE_EDGE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH = 1'd1;

  localparam logic [TIME_W-1:0] MIN_WIDTH_RST = '0;
  localparam logic [TIME_W-1:0] MAX_WIDTH_RST = '1;

  typedef logic [TIME_W-1:0] tick_t;

  // one request to the channel bank
  typedef struct packed {
    logic          edge_en;
    logic          tick_en;
    logic [CH_W-1:0] chan;
    tick_t         edge_time;
  } chan_req_t;

endpackage

`default_nettype wire

/* rtl/rpwc_chan_bank.sv */
// per-channel state: last edge time, width, seen and valid flags
// depends on rpwc_pkg
`default_nettype none

module rpwc_chan_bank
  import rpwc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire chan_req_t req,
  input  wire tick_t     min_width,
  input  wire tick_t     max_width,
  output tick_t          rd_width
);

  tick_t last_r  [NUM_CHANNELS];
  tick_t width_r [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] seen_r;
  logic [NUM_CHANNELS-1:0] valid_r;

  logic                in_range;
  logic [CH_IDX_W-1:0] idx;
  tick_t               prev;
  tick_t               gap;
  logic                good;

  assign in_range = int'(req.chan) < int'(NUM_CHANNELS);
  assign idx      = req.chan[CH_IDX_W-1:0];
  assign prev     = last_r[idx];

  // on wrap the distance is (top - prev) + now, i.e. ~prev + now
  always_comb begin
    if (req.edge_time > prev) begin
      gap = req.edge_time - prev;
    end else begin
      gap = ~prev + req.edge_time;
    end
  end

  assign good = (gap > min_width) && (gap < max_width);

  always_comb begin
    if (in_range && valid_r[idx]) begin
      rd_width = width_r[idx];
    end else begin
      rd_width = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      valid_r <= '0;
      for (int i = 0; i < int'(NUM_CHANNELS); i++) begin
        last_r[i]  <= '0;
        width_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < int'(NUM_CHANNELS); i++) begin
        if (req.edge_en && in_range && (idx == CH_IDX_W'(i))) begin
          last_r[i] <= req.edge_time;
          if (good) begin
            width_r[i] <= gap;
            valid_r[i] <= 1'b1;
            seen_r[i]  <= 1'b1;
          end
        end else if (req.tick_en) begin
          if (seen_r[i]) begin
            seen_r[i] <= 1'b0;
          end else begin
            valid_r[i] <= 1'b0;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/rc_pulse_width_capture_top.sv */
// rc pulse width capture: a request is accepted into the input register, and a read
// result is then registered in the result register
// throughput one request per cycle; a read waits only while the result register
// is held by out_stall
// synchronous active-low reset clears all channel state, flags and both stages,
// min_width to 0 and max_width to 65535
// depends on rpwc_pkg and rpwc_chan_bank
`default_nettype none

module rc_pulse_width_capture_top
  import rpwc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [MODE_W-1:0]    in_mode,
  input  wire logic [CH_W-1:0]      in_channel_index,
  input  wire logic [TIME_W-1:0]    in_edge_time,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [TIME_W-1:0]         out_width_out,
  output logic [CH_W-1:0]           out_read_channel,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TIME_W-1:0]    cfg_data
);

  tick_t min_r, max_r;

  logic              s1_valid_r;
  logic [MODE_W-1:0] s1_mode_r;
  logic [CH_W-1:0]   s1_ch_r;
  tick_t             s1_time_r;

  logic              out_valid_r;
  tick_t             out_width_r;
  logic [CH_W-1:0]   out_ch_r;

  logic      out_free;
  logic      s1_fire;
  chan_req_t req;
  tick_t     rd_width;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= MIN_WIDTH_RST;
      max_r <= MAX_WIDTH_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MIN_WIDTH: min_r <= cfg_data;
        REG_MAX_WIDTH: max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  // only a read needs the result register
  assign s1_fire  = s1_valid_r && ((s1_mode_r != MODE_READ) || out_free);
  assign in_stall = s1_valid_r && !s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_mode_r <= in_mode;
      s1_ch_r   <= in_channel_index;
      s1_time_r <= in_edge_time;
    end
  end

  always_comb begin
    req.edge_en   = s1_fire && (s1_mode_r == MODE_EDGE);
    req.tick_en   = s1_fire && (s1_mode_r == MODE_TICK);
    req.chan      = s1_ch_r;
    req.edge_time = s1_time_r;
  end

  rpwc_chan_bank u_bank (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .min_width (min_r),
    .max_width (max_r),
    .rd_width  (rd_width)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_fire && (s1_mode_r == MODE_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_fire && (s1_mode_r == MODE_READ)) begin
      out_width_r <= rd_width;
      out_ch_r    <= s1_ch_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_width_out    = out_width_r;
  assign out_read_channel = out_ch_r;

endmodule

`default_nettype wire

/* test/rc_pulse_width_capture_top_tb.sv */
// self-checking testbench for rc_pulse_width_capture_top: directed table, then random phases
// predicts each unpinned read from its own per-channel copy of the capture state; pinned reads use the table value
// depends on rpwc_pkg and the rc_pulse_width_capture_top rtl
module rc_pulse_width_capture_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rpwc_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int TIMER_TOP      = 65535;
  localparam int LATENCY        = 2;
  localparam int DRAIN_CYCLES   = LATENCY + 3;
  localparam int RESET_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASES         = 6;
  localparam int PRESSURE_PHASE = 4;
  localparam int PHASE_ITEMS    = 72;
  localparam int DIR_N          = 24;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CH_W-1:0]   chan;
    tick_t             stamp;
    logic              pinned;        // read result typed into the table
    tick_t             pinned_width;
  } capture_req_t;

  typedef struct packed {
    tick_t           width;
    logic [CH_W-1:0] chan;
  } width_read_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [MODE_W-1:0] in_mode = '0;
  logic [CH_W-1:0]   in_channel_index = '0;
  tick_t             in_edge_time = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  tick_t             out_width_out;
  logic [CH_W-1:0]   out_read_channel;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  tick_t             cfg_data = '0;

  rc_pulse_width_capture_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_channel_index (in_channel_index),
    .in_edge_time     (in_edge_time),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_width_out    (out_width_out),
    .out_read_channel (out_read_channel),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted capture state
  tick_t edge_stamp_q [NUM_CHANNELS] = '{default: '0};
  tick_t width_q      [NUM_CHANNELS] = '{default: '0};
  logic  seen_q       [NUM_CHANNELS] = '{default: 1'b0};
  logic  valid_q      [NUM_CHANNELS] = '{default: 1'b0};
  tick_t min_width_q = '0;
  tick_t max_width_q = '1;

  capture_req_t capture_reqs[$];
  width_read_t  width_reads_due[$];
  int           reqs_in_flight = 0;
  int           err_cnt = 0;
  int           quiet_cycles = 0;
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  logic         hold_req = 1'b0;
  logic         hold_ack = 1'b0;
  int           hold_left = 0;
  tick_t        stim_stamp [NUM_CHANNELS];

  capture_req_t cur_req;
  logic         sender_busy;
  logic         got_read;
  width_read_t  read_due;
  width_read_t  read_seen;

  capture_req_t directed_reqs [DIR_N] = '{
    '{MODE_READ,   3'd0, 16'd0,     1'b1, 16'd0},      // read right after reset
    '{MODE_EDGE,   3'd0, 16'hFFFF,  1'b0, 16'd0},      // width equals max, rejected
    '{MODE_READ,   3'd0, 16'd0,     1'b1, 16'd0},
    '{MODE_EDGE,   3'd1, 16'd1000,  1'b0, 16'd0},
    '{MODE_READ,   3'd1, 16'd0,     1'b1, 16'd1000},
    '{MODE_EDGE,   3'd1, 16'd500,   1'b0, 16'd0},      // timer wrapped
    '{MODE_READ,   3'd1, 16'd0,     1'b1, 16'd65035},
    '{MODE_EDGE,   3'd2, 16'd0,     1'b0, 16'd0},      // same time as last edge
    '{MODE_READ,   3'd2, 16'd0,     1'b1, 16'd0},
    '{MODE_TICK,   3'd5, 16'hAAAA,  1'b0, 16'd0},
    '{MODE_READ,   3'd1, 16'd0,     1'b1, 16'd65035},  // seen cleared, still valid
    '{MODE_TICK,   3'd2, 16'h5555,  1'b0, 16'd0},
    '{MODE_READ,   3'd1, 16'd0,     1'b1, 16'd0},      // aged out
    '{MODE_EDGE,   3'd7, 16'd1,     1'b0, 16'd0},
    '{MODE_READ,   3'd7, 16'd0,     1'b1, 16'd1},
    '{MODE_EDGE,   3'd7, 16'hFFFF,  1'b0, 16'd0},
    '{MODE_READ,   3'd7, 16'd0,     1'b1, 16'd65534},
    '{MODE_UNUSED, 3'd7, 16'hFFFF,  1'b0, 16'd0},
    '{MODE_UNUSED, 3'd0, 16'd0,     1'b0, 16'd0},
    '{MODE_EDGE,   3'd3, 16'hFFFF,  1'b0, 16'd0},
    '{MODE_EDGE,   3'd3, 16'd0,     1'b0, 16'd0},      // wrap to zero width, rejected
    '{MODE_READ,   3'd3, 16'd0,     1'b1, 16'd0},
    '{MODE_READ,   3'd4, 16'd0,     1'b1, 16'd0},
    '{MODE_READ,   3'd7, 16'd0,     1'b0, 16'd0}
  };

  int unsigned phase_min [PHASES] = '{0, 1000, 65535, 0, 65534, 0};
  int unsigned phase_max [PHASES] = '{65535, 2000, 0, 2, 65535, 0};

  function automatic void predict_capture(input capture_req_t r, output logic has_read,
                                          output width_read_t rd);
    int    span;
    tick_t prev;
    has_read = 1'b0;
    rd = '0;
    case (r.mode)
      MODE_EDGE: begin
        prev = edge_stamp_q[r.chan];
        if (r.stamp > prev) span = int'(r.stamp) - int'(prev);
        else span = TIMER_TOP - int'(prev) + int'(r.stamp);
        if (span > int'(min_width_q) && span < int'(max_width_q)) begin
          width_q[r.chan] = tick_t'(span);
          valid_q[r.chan] = 1'b1;
          seen_q[r.chan]  = 1'b1;
        end
        edge_stamp_q[r.chan] = r.stamp;
      end
      MODE_TICK: begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (seen_q[i]) seen_q[i] = 1'b0;
          else valid_q[i] = 1'b0;
        end
      end
      MODE_READ: begin
        has_read = 1'b1;
        rd.chan  = r.chan;
        rd.width = valid_q[r.chan] ? width_q[r.chan] : '0;
      end
      default: ;
    endcase
  endfunction

  // request sender: predicts each request as it is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      sender_busy = in_valid;
      if (in_valid && !in_stall) begin
        predict_capture(cur_req, got_read, read_due);
        if (got_read) begin
          if (cur_req.pinned) read_due.width = cur_req.pinned_width;
          width_reads_due.push_back(read_due);
        end
        reqs_in_flight--;
        sender_busy = 1'b0;
      end
      if (!sender_busy) begin
        if (capture_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = capture_reqs.pop_front();
          in_mode          <= cur_req.mode;
          in_channel_index <= cur_req.chan;
          in_edge_time     <= cur_req.stamp;
          in_valid         <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver, with a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (width_reads_due.size() == 0) begin
        $error("unexpected result: width_out %0d read_channel %0d",
               out_width_out, out_read_channel);
        err_cnt++;
      end else begin
        read_seen = width_reads_due.pop_front();
        if (out_width_out !== read_seen.width) begin
          $error("width_out: expected %0d, actual %0d", read_seen.width, out_width_out);
          err_cnt++;
        end
        if (out_read_channel !== read_seen.chan) begin
          $error("read_channel: expected %0d, actual %0d", read_seen.chan, out_read_channel);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("rc_pulse_width_capture_top_tb failed");
        $finish;
      end
    end
  end

  task automatic wait_quiet();
    while (reqs_in_flight != 0 || width_reads_due.size() != 0) @(posedge clk);
    // edges and ticks leave no result behind, let them settle
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // both registers in one burst so cfg_valid is not dropped between them
  task automatic write_widths(input tick_t min_w, input tick_t max_w);
    cfg_index <= REG_MIN_WIDTH;
    cfg_data  <= min_w;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    min_width_q = min_w;
    cfg_index <= REG_MAX_WIDTH;
    cfg_data  <= max_w;
    do @(posedge clk); while (!cfg_ready);
    max_width_q = max_w;
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_random_reqs(input int unsigned lo, input int unsigned hi);
    capture_req_t r;
    int           counted;
    int unsigned  roll;
    counted = 0;
    while (counted < PHASE_ITEMS) begin
      roll  = $urandom_range(99);
      r     = '0;
      r.chan  = CH_W'($urandom_range(NUM_CHANNELS - 1));
      r.stamp = tick_t'($urandom_range(TIMER_TOP));
      if (roll < 58) begin
        r.mode = MODE_EDGE;
        // mostly a well-formed pulse around the accepted window
        if ($urandom_range(9) < 8) r.stamp = stim_stamp[r.chan] + tick_t'($urandom_range(hi, lo));
        stim_stamp[r.chan] = r.stamp;
        counted++;
      end else if (roll < 90) begin
        r.mode = MODE_READ;
        counted++;
      end else if (roll < 96) begin
        r.mode = MODE_TICK;
        counted++;
      end else begin
        r.mode = MODE_UNUSED;
      end
      capture_reqs.push_back(r);
      reqs_in_flight++;
    end
  endtask

  initial begin
    int unsigned mn, mx, lo, hi, swap;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      capture_reqs.push_back(directed_reqs[i]);
      reqs_in_flight++;
    end
    wait_quiet();

    for (int ph = 0; ph < PHASES; ph++) begin
      mn = phase_min[ph];
      mx = phase_max[ph];
      if (ph == PHASES - 1) begin
        mn = $urandom_range(3000);
        mx = mn + 2 + $urandom_range(4000);
      end
      write_widths(tick_t'(mn), tick_t'(mx));
      case (idle_mode_t'(ph % 4))
        IDLE_NONE: begin send_idle_pct = 0;  stall_pct = 0;  end
        IDLE_SEND: begin send_idle_pct = 87; stall_pct = 0;  end
        IDLE_RECV: begin send_idle_pct = 0;  stall_pct = 87; end
        default:   begin send_idle_pct = 33; stall_pct = 33; end
      endcase
      stim_stamp = edge_stamp_q;
      lo = (mn > 3) ? mn - 3 : 0;
      hi = (mx < TIMER_TOP - 3) ? mx + 3 : TIMER_TOP;
      if (lo > hi) begin
        swap = lo;
        lo = hi;
        hi = swap;
      end
      queue_random_reqs(lo, hi);
      if (ph == PRESSURE_PHASE) hold_req = ~hold_req;
      wait_quiet();
    end

    if (err_cnt == 0 && width_reads_due.size() == 0) begin
      $display("rc_pulse_width_capture_top_tb passed");
    end else begin
      $display("rc_pulse_width_capture_top_tb failed");
    end
    $finish;
  end

endmodule
